FILE: design/fpa_pkg.sv
package fpa_pkg;

   // Number format
   localparam int FRACTION_BITS = 8;
   localparam int WORD_WIDTH    = 32;
   localparam int WORD_BITS     = (WORD_WIDTH > 32) ? 32 : WORD_WIDTH;
   localparam int OPND_W        = 32;
   localparam int NUM_W         = OPND_W + FRACTION_BITS;
   localparam int PROD_W        = 2 * OPND_W;
   localparam int WIDE_W        = PROD_W + 2;

   // Saturation bounds of the word range, sign-extended to the wide width
   localparam logic signed [WIDE_W-1:0] SAT_HI =
      {{(WIDE_W - WORD_BITS + 1){1'b0}}, {(WORD_BITS - 1){1'b1}}};
   localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

   typedef enum logic [3:0] {
      KIND_ADD      = 4'd0,
      KIND_SUB      = 4'd1,
      KIND_MUL      = 4'd2,
      KIND_DIV      = 4'd3,
      KIND_GT       = 4'd4,
      KIND_LT       = 4'd5,
      KIND_GE       = 4'd6,
      KIND_LE       = 4'd7,
      KIND_EQ       = 4'd8,
      KIND_NE       = 4'd9,
      KIND_MIN      = 4'd10,
      KIND_MAX      = 4'd11,
      KIND_INC      = 4'd12,
      KIND_DEC      = 4'd13,
      KIND_FROM_INT = 4'd14,
      KIND_TO_INT   = 4'd15
   } fpa_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_DIV_ZERO = 2'd2
   } fpa_status_type;

   typedef struct packed {
      logic [3:0]               kind;
      logic signed [OPND_W-1:0] operand_a;
      logic signed [OPND_W-1:0] operand_b;
   } fpa_req_type;

   typedef struct packed {
      logic signed [OPND_W-1:0] result;
      logic                     compare_true;
      logic [1:0]               status;
   } fpa_rsp_type;

   // Work item carried down the divider chain
   typedef struct packed {
      fpa_kind_type             kind;
      logic                     neg;
      logic                     div_zero;
      logic [NUM_W-1:0]         num;
      logic [OPND_W-1:0]        den;
      logic [OPND_W-1:0]        rem;
      logic signed [PROD_W-1:0] prod;
      fpa_rsp_type              simple;
   } fpa_token_type;

   typedef struct packed {
      logic [OPND_W-1:0] value;
      logic              ovf;
   } fpa_sat_type;

   // Clamp a wide signed value to the word range
   function automatic fpa_sat_type fpa_saturate(input logic signed [WIDE_W-1:0] v);
      fpa_sat_type s;
      if (v > SAT_HI) begin
         s.value = SAT_HI[OPND_W-1:0];
         s.ovf   = 1'b1;
      end else if (v < SAT_LO) begin
         s.value = SAT_LO[OPND_W-1:0];
         s.ovf   = 1'b1;
      end else begin
         s.value = v[OPND_W-1:0];
         s.ovf   = 1'b0;
      end
      return s;
   endfunction

endpackage

FILE: design/fpa_front.sv
module fpa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  req_valid,
   input  fpa_pkg::fpa_req_type  req_payload,
   output logic                  tok_valid_ff,
   output fpa_pkg::fpa_token_type tok_ff
);

   logic signed [fpa_pkg::OPND_W-1:0] a;
   logic signed [fpa_pkg::OPND_W-1:0] b;
   logic signed [fpa_pkg::WIDE_W-1:0] wa;
   logic signed [fpa_pkg::WIDE_W-1:0] wb;
   logic [fpa_pkg::OPND_W-1:0]        mag_a;
   logic [fpa_pkg::OPND_W-1:0]        mag_b;
   fpa_pkg::fpa_sat_type              sat;
   fpa_pkg::fpa_token_type            tok_in;

   assign a     = req_payload.operand_a;
   assign b     = req_payload.operand_b;
   assign wa    = {{(fpa_pkg::WIDE_W - fpa_pkg::OPND_W){a[fpa_pkg::OPND_W-1]}}, a};
   assign wb    = {{(fpa_pkg::WIDE_W - fpa_pkg::OPND_W){b[fpa_pkg::OPND_W-1]}}, b};
   assign mag_a = a[fpa_pkg::OPND_W-1] ? (~a + 1'b1) : a;
   assign mag_b = b[fpa_pkg::OPND_W-1] ? (~b + 1'b1) : b;

   // Decode the operation and finish everything except multiply and divide
   always_comb begin
      sat                 = '0;
      tok_in.kind         = fpa_pkg::fpa_kind_type'(req_payload.kind);
      tok_in.neg          = a[fpa_pkg::OPND_W-1] ^ b[fpa_pkg::OPND_W-1];
      tok_in.div_zero     = (b == '0);
      tok_in.num          = {mag_a, {fpa_pkg::FRACTION_BITS{1'b0}}};
      tok_in.den          = mag_b;
      tok_in.rem          = '0;
      tok_in.prod         = a * b;
      tok_in.simple       = '0;
      case (tok_in.kind)
         fpa_pkg::KIND_ADD:      sat = fpa_pkg::fpa_saturate(wa + wb);
         fpa_pkg::KIND_SUB:      sat = fpa_pkg::fpa_saturate(wa - wb);
         fpa_pkg::KIND_INC:      sat = fpa_pkg::fpa_saturate(wa + fpa_pkg::WIDE_W'(1));
         fpa_pkg::KIND_DEC:      sat = fpa_pkg::fpa_saturate(wa - fpa_pkg::WIDE_W'(1));
         fpa_pkg::KIND_FROM_INT: sat = fpa_pkg::fpa_saturate(wa <<< fpa_pkg::FRACTION_BITS);
         default:                sat = '0;
      endcase
      case (tok_in.kind)
         fpa_pkg::KIND_ADD, fpa_pkg::KIND_SUB, fpa_pkg::KIND_INC,
         fpa_pkg::KIND_DEC, fpa_pkg::KIND_FROM_INT: begin
            tok_in.simple.result = sat.value;
            tok_in.simple.status = sat.ovf ? fpa_pkg::STATUS_OVERFLOW : fpa_pkg::STATUS_OK;
         end
         fpa_pkg::KIND_GT: tok_in.simple.compare_true = (a > b);
         fpa_pkg::KIND_LT: tok_in.simple.compare_true = (a < b);
         fpa_pkg::KIND_GE: tok_in.simple.compare_true = (a >= b);
         fpa_pkg::KIND_LE: tok_in.simple.compare_true = (a <= b);
         fpa_pkg::KIND_EQ: tok_in.simple.compare_true = (a == b);
         fpa_pkg::KIND_NE: tok_in.simple.compare_true = (a != b);
         fpa_pkg::KIND_MIN: tok_in.simple.result = (a < b) ? a : b;
         fpa_pkg::KIND_MAX: tok_in.simple.result = (a > b) ? a : b;
         fpa_pkg::KIND_TO_INT: tok_in.simple.result = a >>> fpa_pkg::FRACTION_BITS;
         fpa_pkg::KIND_DIV: begin
            if (tok_in.div_zero) begin
               tok_in.simple.status = fpa_pkg::STATUS_DIV_ZERO;
            end
         end
         default: tok_in.simple = '0;
      endcase
   end

   // Capture the transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else if (enable) begin
         tok_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         tok_ff <= tok_in;
      end
   end

endmodule

FILE: design/fpa_div_cell.sv
module fpa_div_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  fpa_pkg::fpa_token_type in_tok,
   output logic                   out_valid_ff,
   output fpa_pkg::fpa_token_type out_tok_ff
);

   logic [fpa_pkg::OPND_W:0] shifted;
   logic                     take;
   fpa_pkg::fpa_token_type   tok_in;

   // One restoring step: bring down a dividend bit, subtract if it fits
   always_comb begin
      shifted = {in_tok.rem, in_tok.num[fpa_pkg::NUM_W-1]};
      take    = (shifted >= {1'b0, in_tok.den});
      tok_in  = in_tok;
      tok_in.num = {in_tok.num[fpa_pkg::NUM_W-2:0], take};
      if (take) begin
         tok_in.rem = fpa_pkg::OPND_W'(shifted - {1'b0, in_tok.den});
      end else begin
         tok_in.rem = shifted[fpa_pkg::OPND_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_tok_ff <= tok_in;
      end
   end

endmodule

FILE: design/fpa_back.sv
module fpa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   tok_valid,
   input  fpa_pkg::fpa_token_type tok,
   output logic                   rsp_valid_ff,
   output fpa_pkg::fpa_rsp_type   rsp_ff
);

   logic [fpa_pkg::PROD_W-1:0]        prod_mag;
   logic [fpa_pkg::PROD_W-1:0]        mul_mag;
   logic                              round_up;
   logic [fpa_pkg::NUM_W:0]           div_mag;
   logic signed [fpa_pkg::WIDE_W-1:0] mul_wide;
   logic signed [fpa_pkg::WIDE_W-1:0] div_wide;
   fpa_pkg::fpa_sat_type              sat;
   fpa_pkg::fpa_rsp_type              rsp_in;

   // Round the product half away from zero
   assign prod_mag = tok.prod[fpa_pkg::PROD_W-1] ? (~tok.prod + 1'b1) : tok.prod;
   assign mul_mag  = (prod_mag + (fpa_pkg::PROD_W'(1) << (fpa_pkg::FRACTION_BITS - 1)))
                     >> fpa_pkg::FRACTION_BITS;
   assign mul_wide = tok.prod[fpa_pkg::PROD_W-1]
                     ? -$signed({2'b00, mul_mag}) : $signed({2'b00, mul_mag});

   // Round the quotient up when twice the remainder reaches the divisor
   assign round_up = ({tok.rem, 1'b0} >= {1'b0, tok.den});
   assign div_mag  = {1'b0, tok.num} + (fpa_pkg::NUM_W + 1)'(round_up);
   assign div_wide = tok.neg
                     ? -$signed({{(fpa_pkg::WIDE_W - fpa_pkg::NUM_W - 1){1'b0}}, div_mag})
                     : $signed({{(fpa_pkg::WIDE_W - fpa_pkg::NUM_W - 1){1'b0}}, div_mag});

   always_comb begin
      sat    = '0;
      rsp_in = tok.simple;
      case (tok.kind)
         fpa_pkg::KIND_MUL: begin
            sat           = fpa_pkg::fpa_saturate(mul_wide);
            rsp_in.result = sat.value;
            rsp_in.status = sat.ovf ? fpa_pkg::STATUS_OVERFLOW : fpa_pkg::STATUS_OK;
         end
         fpa_pkg::KIND_DIV: begin
            if (!tok.div_zero) begin
               sat           = fpa_pkg::fpa_saturate(div_wide);
               rsp_in.result = sat.value;
               rsp_in.status = sat.ovf ? fpa_pkg::STATUS_OVERFLOW : fpa_pkg::STATUS_OK;
            end
         end
         default: rsp_in = tok.simple;
      endcase
   end

   // Hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= tok_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

FILE: design/fixed_point_alu_top.sv
// Signed Q24.8 fixed-point ALU.
// Input channel req_valid/req_ready/req_payload carries an opcode and two
// raw operands; result channel rsp_valid/rsp_ready/rsp_payload returns one
// result, a comparison flag and a status code for every transaction.
// The pipeline has one decode stage (operand setup, single 32x32
// multiplier), a chain of 40 divider cells that each retire one quotient
// bit, and one rounding/saturation stage that drives the output register.
// Every operation takes the same path, so results leave in order.
// Throughput is one transaction per cycle while rsp_ready is high.
// When the receiver stalls with a result waiting, the whole chain freezes
// and req_ready drops; items in flight keep their place and resume when
// rsp_ready returns. Reset clears all valid bits; no transaction is lost
// or repeated across a stall.
module fixed_point_alu_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpa_pkg::fpa_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fpa_pkg::fpa_rsp_type rsp_payload
);

   logic                   enable;
   logic                   chain_valid [fpa_pkg::NUM_W+1];
   fpa_pkg::fpa_token_type chain_tok   [fpa_pkg::NUM_W+1];

   // Advance everything unless a result waits on a stalled receiver
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   fpa_front u_front (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .req_valid    (req_valid),
      .req_payload  (req_payload),
      .tok_valid_ff (chain_valid[0]),
      .tok_ff       (chain_tok[0])
   );

   for (genvar i = 0; i < fpa_pkg::NUM_W; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .enable       (enable),
         .in_valid     (chain_valid[i]),
         .in_tok       (chain_tok[i]),
         .out_valid_ff (chain_valid[i+1]),
         .out_tok_ff   (chain_tok[i+1])
      );
   end

   fpa_back u_back (
      .clock        (clock),
      .reset        (reset),
      .enable       (enable),
      .tok_valid    (chain_valid[fpa_pkg::NUM_W]),
      .tok          (chain_tok[fpa_pkg::NUM_W]),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_payload)
   );

endmodule

FILE: test/fpa_checker.sv
`timescale 1ns / 1ps

module fpa_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  fpa_pkg::fpa_req_type req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  fpa_pkg::fpa_rsp_type rsp_payload,
   output int                   fail_count,
   output int                   pending_count,
   output int                   result_count
);

   fpa_pkg::fpa_rsp_type expected_rsps[$];

   // Clamp to the signed word range, flag overflow
   function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v,
                                                     inout logic [1:0] st);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (fpa_pkg::WORD_BITS - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         st = fpa_pkg::STATUS_OVERFLOW;
         return hi;
      end
      if (v < lo) begin
         st = fpa_pkg::STATUS_OVERFLOW;
         return lo;
      end
      return v;
   endfunction

   function automatic logic [63:0] abs64(input logic signed [63:0] v);
      return v < 0 ? 64'd0 - 64'(v) : 64'(v);
   endfunction

   // Compute the ALU response for one request
   function automatic fpa_pkg::fpa_rsp_type alu_response(input fpa_pkg::fpa_req_type rq);
      logic signed [63:0] a;
      logic signed [63:0] b;
      logic signed [63:0] r;
      logic signed [63:0] p;
      logic [63:0] m;
      logic [1:0] st;
      logic cmp;
      fpa_pkg::fpa_rsp_type o;
      a = 64'(rq.operand_a);
      b = 64'(rq.operand_b);
      r = 0;
      st = fpa_pkg::STATUS_OK;
      cmp = 1'b0;
      case (fpa_pkg::fpa_kind_type'(rq.kind))
         fpa_pkg::KIND_ADD: r = clamp_word(a + b, st);
         fpa_pkg::KIND_SUB: r = clamp_word(a - b, st);
         fpa_pkg::KIND_MUL: begin
            p = a * b;
            m = (abs64(p) + (64'd1 << (fpa_pkg::FRACTION_BITS - 1)))
                >> fpa_pkg::FRACTION_BITS;
            r = clamp_word(p < 0 ? -$signed(m) : $signed(m), st);
         end
         fpa_pkg::KIND_DIV: begin
            if (b == 0) begin
               st = fpa_pkg::STATUS_DIV_ZERO;
            end else begin
               m = (2 * (abs64(a) << fpa_pkg::FRACTION_BITS) + abs64(b)) / (2 * abs64(b));
               r = clamp_word(((a < 0) != (b < 0)) ? -$signed(m) : $signed(m), st);
            end
         end
         fpa_pkg::KIND_GT: cmp = a > b;
         fpa_pkg::KIND_LT: cmp = a < b;
         fpa_pkg::KIND_GE: cmp = a >= b;
         fpa_pkg::KIND_LE: cmp = a <= b;
         fpa_pkg::KIND_EQ: cmp = a == b;
         fpa_pkg::KIND_NE: cmp = a != b;
         fpa_pkg::KIND_MIN: r = (a < b) ? a : b;
         fpa_pkg::KIND_MAX: r = (a > b) ? a : b;
         fpa_pkg::KIND_INC: r = clamp_word(a + 1, st);
         fpa_pkg::KIND_DEC: r = clamp_word(a - 1, st);
         fpa_pkg::KIND_FROM_INT:
            r = clamp_word(a * (64'sd1 <<< fpa_pkg::FRACTION_BITS), st);
         default: r = a >>> fpa_pkg::FRACTION_BITS;
      endcase
      o.result = r[31:0];
      o.compare_true = cmp;
      o.status = st;
      return o;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      result_count = 0;
      pending_count = 0;
   end

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      fpa_pkg::fpa_rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) expected_rsps.push_back(alu_response(req_payload));
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (expected_rsps.size() == 0) begin
               report_mismatch("response with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_payload.result !== want.result)
                  report_mismatch($sformatf("result %h, expected %h",
                                            rsp_payload.result, want.result));
               if (rsp_payload.compare_true !== want.compare_true)
                  report_mismatch($sformatf("compare_true %b, expected %b",
                                            rsp_payload.compare_true, want.compare_true));
               if (rsp_payload.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_payload.status, want.status));
            end
         end
         pending_count = expected_rsps.size();
      end
   end
endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int LATENCY = 42;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   fpa_pkg::fpa_req_type req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   fpa_pkg::fpa_rsp_type rsp_payload;
   int                   fail_count;
   int                   pending_count;
   int                   result_count;
   int                   idle_cycles = 0;
   int                   sender_idle_pct = 0;
   int                   receiver_stall_pct = 0;
   int                   sent_count = 0;

   always #5 clock = ~clock;

   fixed_point_alu_top DUT (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   fpa_checker checker_inst (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_payload(req_payload), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload), .fail_count(fail_count),
      .pending_count(pending_count), .result_count(result_count)
   );

   // Stall the receiver at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Watchdog on accepted transactions
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return 32'($signed($urandom_range(2047)) - 1024);
         3: return 32'($signed($urandom_range(65535)) - 32768) <<< 8;
         4: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
         5: return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Present one request, hold until accepted; drop valid only while idling
   task automatic send_request(input logic [3:0] kind, input logic [31:0] a,
                               input logic [31:0] b);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{kind: kind, operand_a: a, operand_b: b};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   // Stop sending and wait for every expected result
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      logic [3:0] k;
      logic [31:0] a;
      logic [31:0] b;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every operation at the extremes plus named corner cases
      for (int i = 0; i < 16; i++)
         send_request(i[3:0], 32'h7fffffff, i[0] ? 32'h80000000 : 32'h7fffffff);
      send_request(fpa_pkg::KIND_DIV, 32'h00000100, 32'h0);
      send_request(fpa_pkg::KIND_MIN, 32'h00000500, 32'h00000500);
      send_request(fpa_pkg::KIND_MAX, 32'hfffffe00, 32'hfffffe00);
      send_request(fpa_pkg::KIND_INC, 32'h7fffffff, 32'h0);
      send_request(fpa_pkg::KIND_DEC, 32'h80000000, 32'h0);
      send_request(fpa_pkg::KIND_TO_INT, 32'hffffff01, 32'h0);
      send_request(fpa_pkg::KIND_MUL, 32'hffffff80, 32'h00000001);
      send_request(fpa_pkg::KIND_DIV, 32'h80000000, 32'hffffffff);
      send_request(fpa_pkg::KIND_FROM_INT, 32'hff800000, 32'h0);
      drain_results();

      // Random phases with different idling mixes
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 65; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 65; end
            default: begin sender_idle_pct = 23; receiver_stall_pct = 23; end
         endcase
         for (int n = 0; n < 500; n++) begin
            k = 4'($urandom);
            a = pick_operand();
            b = ($urandom_range(9) == 0) ? a : pick_operand();
            send_request(k, a, b);
            if (n == 250) drain_results();
         end
      end

      drain_results();
      repeat (LATENCY + 8) @(posedge clock);
      $display("covered %0d requests, all 16 operations, four idle/stall mixes", sent_count);
      $display("checked %0d responses", result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
